### rtl/core/cmb_pkg.sv
// Shared types, codes and constants for the cartridge mapper with banks,
// scanline IRQ counter and serial misc-ROM pointer.
// No dependencies.
package cmb_pkg;

	localparam int TYPE_W  = 2;
	localparam int ADDR_W  = 16;
	localparam int DATA_W  = 8;
	localparam int SPACE_W = 2;
	localparam int RADDR_W = 20;
	localparam int BANK_W  = 6;
	localparam int NBANK   = 4;
	localparam int PTR_W   = 32;
	localparam int CNT_W   = 8;

	localparam int PRG_ROM_KB_DEF   = 512;
	localparam int CHR_ROM_KB_DEF   = 256;
	localparam int MISC_ADDR_W_DEF  = 16;

	typedef enum logic [TYPE_W-1:0] {
		REQ_WR   = 2'd0,
		REQ_RD   = 2'd1,
		REQ_TICK = 2'd2,
		REQ_PPU  = 2'd3
	} req_t;

	typedef enum logic [SPACE_W-1:0] {
		SPACE_NONE = 2'd0,
		SPACE_PRG  = 2'd1,
		SPACE_MISC = 2'd2,
		SPACE_CHR  = 2'd3
	} space_t;

	// CPU write targets, by address bits 15:12
	localparam logic [3:0] WR_LATCH  = 4'h8;
	localparam logic [3:0] WR_CLR    = 4'h9;
	localparam logic [3:0] WR_DIS    = 4'hA;
	localparam logic [3:0] WR_EN     = 4'hB;
	localparam logic [3:0] WR_SERIAL = 4'hC;
	localparam logic [3:0] WR_CTRL   = 4'hD;
	localparam logic [3:0] WR_BANK_E = 4'hE;
	localparam logic [3:0] WR_BANK_F = 4'hF;

	localparam logic [ADDR_W-1:0] MISC_MASK  = 16'hF800;
	localparam logic [ADDR_W-1:0] MISC_WIN_A = 16'h4800;
	localparam logic [ADDR_W-1:0] MISC_WIN_B = 16'hC000;
	localparam logic [ADDR_W-1:0] MISC_WIN_C = 16'hC800;
	localparam logic [ADDR_W-1:0] CHR_HI     = 16'h1000;
	localparam logic [DATA_W-1:0] BANK_MASK  = 8'h3F;
	localparam logic [DATA_W-1:0] AUTOINC_BIT = 8'h02;

	localparam int CHR_HI_BANK = 8'hFD;
	localparam int PRG_E_BANK  = 4;
	localparam int PRG_D_BANK  = 7;
	localparam int PRG_5_BANK  = 1;

	typedef struct packed {
		logic [NBANK-1:0][BANK_W-1:0] bank;
		logic [PTR_W-1:0]             ptr;
		logic                         pending;
	} cmb_state_t;

	typedef struct packed {
		space_t             space;
		logic [RADDR_W-1:0] raddr;
		logic               misc_hit;
	} cmb_dec_t;

endpackage

### rtl/core/cmb_bank_mod.sv
// Bank number reduced modulo the bank count of a ROM, as a constant table.
// Depends on cmb_pkg.
module cmb_bank_mod #(
	parameter int BANKS = 8
) (
	input  logic [cmb_pkg::BANK_W-1:0] bank,
	output logic [cmb_pkg::BANK_W-1:0] bank_red
);
	import cmb_pkg::*;

	localparam int ENTRIES = 1 << BANK_W;

	logic [ENTRIES-1:0][BANK_W-1:0] tbl;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_ent
		localparam int REM = i % BANKS;
		assign tbl[i] = BANK_W'(REM);
	end

	assign bank_red = tbl[bank];

endmodule

### rtl/core/cmb_decode.sv
// Read address translation: CPU reads to PRG or misc ROM, PPU reads to CHR ROM.
// Depends on cmb_pkg and cmb_bank_mod.
module cmb_decode #(
	parameter int PRG_ROM_KB  = cmb_pkg::PRG_ROM_KB_DEF,
	parameter int CHR_ROM_KB  = cmb_pkg::CHR_ROM_KB_DEF,
	parameter int MISC_ADDR_W = cmb_pkg::MISC_ADDR_W_DEF
) (
	input  cmb_pkg::req_t                  req,
	input  logic [cmb_pkg::ADDR_W-1:0]     addr,
	input  cmb_pkg::cmb_state_t            st,
	output cmb_pkg::cmb_dec_t              dec
);
	import cmb_pkg::*;

	localparam int PRG8_BANKS = (PRG_ROM_KB / 8 == 0) ? 1 : PRG_ROM_KB / 8;
	localparam int PRG4_BANKS = (PRG_ROM_KB / 4 == 0) ? 1 : PRG_ROM_KB / 4;
	localparam int CHR4_BANKS = (CHR_ROM_KB / 4 == 0) ? 1 : CHR_ROM_KB / 4;

	localparam logic [RADDR_W-1:0] PRG_E_BASE =
		RADDR_W'((PRG_E_BANK % PRG8_BANKS) * 8192);
	localparam logic [RADDR_W-1:0] PRG_D_BASE =
		RADDR_W'((PRG_D_BANK % PRG4_BANKS) * 4096);
	localparam logic [RADDR_W-1:0] PRG_5_BASE =
		RADDR_W'((PRG_5_BANK % PRG4_BANKS) * 4096);
	localparam logic [RADDR_W-1:0] CHR_HI_BASE =
		RADDR_W'((CHR_HI_BANK % CHR4_BANKS) * 4096);

	logic [BANK_W-1:0]  prg_bank;
	logic [BANK_W-1:0]  prg_red;
	logic [BANK_W-1:0]  chr_red;
	logic [RADDR_W-1:0] prg_sw_addr;
	logic [RADDR_W-1:0] chr_lo_addr;
	logic [ADDR_W-1:0]  top;
	logic               misc_win;

	// switchable 8K PRG windows at 0x6000, 0x8000 and 0xA000
	always_comb begin
		if (addr >= 16'hA000) begin
			prg_bank = st.bank[2];
		end else if (addr >= 16'h8000) begin
			prg_bank = st.bank[1];
		end else begin
			prg_bank = st.bank[0];
		end
	end

	cmb_bank_mod #(.BANKS(PRG8_BANKS)) u_prg_mod (
		.bank     (prg_bank),
		.bank_red (prg_red)
	);

	cmb_bank_mod #(.BANKS(CHR4_BANKS)) u_chr_mod (
		.bank     (st.bank[3]),
		.bank_red (chr_red)
	);

	assign prg_sw_addr = {1'b0, prg_red, addr[12:0]};
	assign chr_lo_addr = {2'b00, chr_red, addr[11:0]};

	assign top      = addr & MISC_MASK;
	assign misc_win = (top == MISC_WIN_A) || (top == MISC_WIN_B) || (top == MISC_WIN_C);

	always_comb begin
		dec.space    = SPACE_NONE;
		dec.raddr    = '0;
		dec.misc_hit = 1'b0;
		case (req)
			REQ_RD: begin
				dec.space = SPACE_PRG;
				if (misc_win) begin
					dec.space    = SPACE_MISC;
					dec.raddr    = RADDR_W'(st.ptr[MISC_ADDR_W-1:0]);
					dec.misc_hit = 1'b1;
				end else if (addr >= 16'hE000) begin
					dec.raddr = PRG_E_BASE | {7'd0, addr[12:0]};
				end else if (addr >= 16'hD000) begin
					dec.raddr = PRG_D_BASE | {8'd0, addr[11:0]};
				end else if (addr >= 16'h6000) begin
					dec.raddr = prg_sw_addr;
				end else if (addr >= 16'h5000) begin
					dec.raddr = PRG_5_BASE | {8'd0, addr[11:0]};
				end else begin
					dec.space = SPACE_NONE;
				end
			end
			REQ_PPU: begin
				dec.space = SPACE_CHR;
				if ((addr & CHR_HI) != '0) begin
					dec.raddr = CHR_HI_BASE | {8'd0, addr[11:0]};
				end else begin
					dec.raddr = chr_lo_addr;
				end
			end
			default: begin
				dec.space = SPACE_NONE;
			end
		endcase
	end

endmodule

### rtl/core/cmb_regs.sv
// Mapper register file: bank registers, serial pointer, IRQ latch and counter.
// Depends on cmb_pkg.
module cmb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       proc,
	input  cmb_pkg::req_t              req,
	input  logic [cmb_pkg::ADDR_W-1:0] addr,
	input  logic [cmb_pkg::DATA_W-1:0] data,
	input  logic                       misc_hit,
	output cmb_pkg::cmb_state_t        st,
	output logic                       pending_d
);
	import cmb_pkg::*;

	logic [NBANK-1:0][BANK_W-1:0] bank_q;
	logic [PTR_W-1:0]             ptr_q;
	logic                         autoinc_q;
	logic [CNT_W-1:0]             reload_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         en_q;
	logic                         pending_q;

	logic [NBANK-1:0][BANK_W-1:0] bank_d;
	logic [PTR_W-1:0]             ptr_d;
	logic                         autoinc_d;
	logic [CNT_W-1:0]             reload_d;
	logic [CNT_W-1:0]             cnt_d;
	logic                         en_d;
	logic [DATA_W-1:0]            bank_val;

	assign bank_val = data & BANK_MASK;

	always_comb begin
		bank_d    = bank_q;
		ptr_d     = ptr_q;
		autoinc_d = autoinc_q;
		reload_d  = reload_q;
		cnt_d     = cnt_q;
		en_d      = en_q;
		pending_d = pending_q;
		if (proc) begin
			case (req)
				REQ_WR: begin
					unique case (addr[15:12])
						WR_LATCH:  reload_d = data;
						WR_CLR:    cnt_d = '0;
						WR_DIS: begin
							en_d      = 1'b0;
							pending_d = 1'b0;
						end
						WR_EN:     en_d = 1'b1;
						WR_SERIAL: ptr_d = {ptr_q[PTR_W-2:0], data[7]};
						WR_CTRL:   autoinc_d = (data & AUTOINC_BIT) != '0;
						WR_BANK_E, WR_BANK_F: bank_d[data[7:6]] = bank_val[BANK_W-1:0];
						default: ;
					endcase
				end
				REQ_RD: begin
					if (misc_hit && autoinc_q) begin
						ptr_d = ptr_q + PTR_W'(1);
					end
				end
				REQ_TICK: begin
					// reload on zero, otherwise count down
					if (cnt_q == '0) begin
						cnt_d = reload_q;
					end else begin
						cnt_d = cnt_q - CNT_W'(1);
					end
					if (cnt_d == '0 && en_q) begin
						pending_d = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q    <= '0;
			ptr_q     <= '0;
			autoinc_q <= 1'b0;
			reload_q  <= '0;
			cnt_q     <= '0;
			en_q      <= 1'b0;
			pending_q <= 1'b0;
		end else begin
			bank_q    <= bank_d;
			ptr_q     <= ptr_d;
			autoinc_q <= autoinc_d;
			reload_q  <= reload_d;
			cnt_q     <= cnt_d;
			en_q      <= en_d;
			pending_q <= pending_d;
		end
	end

	assign st.bank    = bank_q;
	assign st.ptr     = ptr_q;
	assign st.pending = pending_q;

endmodule

### rtl/core/cartridge_mapper_banks_irq_serial.sv
// Cartridge mapper top level: input register, decode and register update, result register.
// An accepted item is decoded from the input register and its result is captured in the result register.
// Throughput: one item per cycle; input stalls only once both the input and result
// registers hold an item while out_ready is low.
// Reset (arst_n low) clears both pipeline valids, all bank registers, the serial pointer,
// the IRQ latch, counter, enable and pending flag at once.
// Depends on cmb_pkg, cmb_regs, cmb_decode and cmb_bank_mod.
module cartridge_mapper_banks_irq_serial #(
	parameter int PRG_ROM_KB  = cmb_pkg::PRG_ROM_KB_DEF,
	parameter int CHR_ROM_KB  = cmb_pkg::CHR_ROM_KB_DEF,
	parameter int MISC_ADDR_W = cmb_pkg::MISC_ADDR_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [cmb_pkg::TYPE_W-1:0]   req_type,
	input  logic [cmb_pkg::ADDR_W-1:0]   bus_address,
	input  logic [cmb_pkg::DATA_W-1:0]   write_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [cmb_pkg::SPACE_W-1:0]  rom_space,
	output logic [cmb_pkg::RADDR_W-1:0]  rom_address,
	output logic                         irq_out
);
	import cmb_pkg::*;

	logic                valid_s1;
	req_t                req_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [DATA_W-1:0]   data_s1;

	logic                valid_s2;
	space_t              space_s2;
	logic [RADDR_W-1:0]  raddr_s2;
	logic                irq_s2;

	logic                out_free;
	logic                proc;
	cmb_state_t          st;
	cmb_dec_t            dec;
	logic                pending_d;

	assign out_free = !valid_s2 || out_ready;
	assign proc     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1  <= req_t'(req_type);
			addr_s1 <= bus_address;
			data_s1 <= write_data;
		end
	end

	cmb_decode #(
		.PRG_ROM_KB  (PRG_ROM_KB),
		.CHR_ROM_KB  (CHR_ROM_KB),
		.MISC_ADDR_W (MISC_ADDR_W)
	) u_decode (
		.req  (req_s1),
		.addr (addr_s1),
		.st   (st),
		.dec  (dec)
	);

	cmb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.proc      (proc),
		.req       (req_s1),
		.addr      (addr_s1),
		.data      (data_s1),
		.misc_hit  (dec.misc_hit),
		.st        (st),
		.pending_d (pending_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			space_s2 <= dec.space;
			raddr_s2 <= dec.raddr;
			irq_s2   <= pending_d;
		end
	end

	assign out_valid   = valid_s2;
	assign rom_space   = space_s2;
	assign rom_address = raddr_s2;
	assign irq_out     = irq_s2;

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && space_s2 == SPACE_NONE |-> raddr_s2 == '0)
		else $error("open-bus result with nonzero address");

	a_irq_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st.pending) |-> $past(proc && req_s1 == REQ_TICK))
		else $error("IRQ raised without a scanline tick");

	a_irq_match: assert property (@(posedge clk) disable iff (!arst_n)
		proc |=> irq_s2 == st.pending)
		else $error("result IRQ level differs from pending flag");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("empty input stage not ready");

endmodule

### test/tb_cartridge_mapper_banks_irq_serial.sv
`timescale 1ns / 100ps
// Testbench for cartridge_mapper_banks_irq_serial: a directed table, then random bus traffic
// under several idle and stall patterns, each result checked against its table entry or a behavioral mapper.
// Depends on cmb_pkg and the mapper RTL.
module tb_cartridge_mapper_banks_irq_serial;
	import cmb_pkg::*;

	localparam int PRG_KB   = PRG_ROM_KB_DEF;
	localparam int CHR_KB   = CHR_ROM_KB_DEF;
	localparam int MISC_W   = MISC_ADDR_W_DEF;
	localparam int WATCHDOG = 4000;
	localparam int HOLD_LEN = 300;
	localparam int DIR_N    = 26;

	typedef struct packed {
		space_t             space;
		logic [RADDR_W-1:0] addr;
		logic               irq;
	} lookup_t;

	typedef struct {
		req_t              kind;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		bit                known;
		lookup_t           exp;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [TYPE_W-1:0] req_type = '0;
	logic [ADDR_W-1:0] bus_address = '0;
	logic [DATA_W-1:0] write_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [SPACE_W-1:0] rom_space;
	logic [RADDR_W-1:0] rom_address;
	logic irq_out;

	// typed expectation travels with the item it belongs to
	bit tag_known = 1'b0;
	lookup_t tag_exp = '0;

	// behavioral mapper state
	logic [BANK_W-1:0] bank_reg [NBANK] = '{default: '0};
	logic [PTR_W-1:0] ser_ptr = '0;
	logic ser_autoinc = 1'b0;
	logic [CNT_W-1:0] irq_latch = '0;
	logic [CNT_W-1:0] irq_cnt = '0;
	logic irq_en = 1'b0;
	logic irq_pend = 1'b0;

	lookup_t exp_lookups [$];
	int fails = 0;
	int idle_cycles = 0;
	int tx_pct = 0;
	int rx_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_cnt = 0;
	dir_row_t dir_tab [DIR_N];

	cartridge_mapper_banks_irq_serial #(
		.PRG_ROM_KB (PRG_KB),
		.CHR_ROM_KB (CHR_KB),
		.MISC_ADDR_W(MISC_W)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.bus_address(bus_address),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.rom_space  (rom_space),
		.rom_address(rom_address),
		.irq_out    (irq_out)
	);

	always #10 clk = ~clk;

	function automatic logic [RADDR_W-1:0] bank_to_rom(int unsigned bank, int unsigned kb,
			int unsigned rom_kb, int unsigned offset);
		int unsigned banks;
		banks = rom_kb / kb;
		if (banks == 0) banks = 1;
		return RADDR_W'((bank % banks) * kb * 1024 + offset);
	endfunction

	function automatic lookup_t translate(req_t kind, logic [ADDR_W-1:0] addr,
			logic [DATA_W-1:0] data);
		lookup_t r;
		logic [ADDR_W-1:0] top;
		logic [PTR_W-1:0] misc_mask;
		int unsigned bank;
		r = '0;
		r.space = SPACE_NONE;
		top = addr & MISC_MASK;
		misc_mask = PTR_W'((64'd1 << MISC_W) - 1);
		case (kind)
		REQ_WR: begin
			case (addr[15:12])
			WR_LATCH: irq_latch = data;
			WR_CLR: irq_cnt = '0;
			WR_DIS: begin
				irq_en = 1'b0;
				irq_pend = 1'b0;
			end
			WR_EN: irq_en = 1'b1;
			WR_SERIAL: ser_ptr = {ser_ptr[PTR_W-2:0], data[7]};
			WR_CTRL: ser_autoinc = data[1];
			WR_BANK_E, WR_BANK_F: bank_reg[data[7:6]] = data[5:0];
			default: ;
			endcase
		end
		REQ_RD: begin
			r.space = SPACE_PRG;
			if (top == MISC_WIN_A || top == MISC_WIN_B || top == MISC_WIN_C) begin
				r.space = SPACE_MISC;
				r.addr = RADDR_W'(ser_ptr & misc_mask);
				if (ser_autoinc) ser_ptr = ser_ptr + 1;
			end else if (addr >= 16'hE000) begin
				r.addr = bank_to_rom(PRG_E_BANK, 8, PRG_KB, addr[12:0]);
			end else if (addr >= 16'hD000) begin
				r.addr = bank_to_rom(PRG_D_BANK, 4, PRG_KB, addr[11:0]);
			end else if (addr >= 16'hA000) begin
				r.addr = bank_to_rom(bank_reg[2], 8, PRG_KB, addr[12:0]);
			end else if (addr >= 16'h8000) begin
				r.addr = bank_to_rom(bank_reg[1], 8, PRG_KB, addr[12:0]);
			end else if (addr >= 16'h6000) begin
				r.addr = bank_to_rom(bank_reg[0], 8, PRG_KB, addr[12:0]);
			end else if (addr >= 16'h5000) begin
				r.addr = bank_to_rom(PRG_5_BANK, 4, PRG_KB, addr[11:0]);
			end else begin
				r.space = SPACE_NONE;
			end
		end
		REQ_TICK: begin
			if (irq_cnt == 0) irq_cnt = irq_latch;
			else irq_cnt = irq_cnt - 1;
			if (irq_cnt == 0 && irq_en) irq_pend = 1'b1;
		end
		default: begin
			bank = ((addr & CHR_HI) != 0) ? CHR_HI_BANK : bank_reg[3];
			r.space = SPACE_CHR;
			r.addr = bank_to_rom(bank, 4, CHR_KB, addr[11:0]);
		end
		endcase
		r.irq = irq_pend;
		return r;
	endfunction

	task automatic send_item(req_t kind, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
			bit known, lookup_t exp);
		while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		bus_address <= addr;
		write_data <= data;
		tag_known <= known;
		tag_exp <= exp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			out_ready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (hold_req && !hold_done) begin
			out_ready <= 1'b0;
			hold_cnt <= HOLD_LEN;
			hold_done <= 1'b1;
		end else begin
			out_ready <= !(rx_pct != 0 && $urandom_range(99) < rx_pct);
		end
	end

	always @(posedge clk) begin
		lookup_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (exp_lookups.size() == 0) begin
					$error("result with no item outstanding: rom_space %0d rom_address %h",
						rom_space, rom_address);
					fails++;
				end else begin
					e = exp_lookups.pop_front();
					if (rom_space !== e.space) begin
						$error("rom_space: expected %0d, got %0d", e.space, rom_space);
						fails++;
					end
					if (rom_address !== e.addr) begin
						$error("rom_address: expected %h, got %h", e.addr, rom_address);
						fails++;
					end
					if (irq_out !== e.irq) begin
						$error("irq_out: expected %0d, got %0d", e.irq, irq_out);
						fails++;
					end
				end
			end
			if (in_valid && in_ready) begin
				e = translate(req_t'(req_type), bus_address, write_data);
				exp_lookups.push_back(tag_known ? tag_exp : e);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG) begin
				$display("** cartridge_mapper_banks_irq_serial: FAILED **");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		logic [ADDR_W-1:0] a;
		logic [DATA_W-1:0] d;
		int sel;
		int cnt;
		dir_tab = '{
			'{REQ_RD,   16'h0000, 8'h00, 1'b1, '{SPACE_NONE, 20'h00000, 1'b0}},
			'{REQ_RD,   16'h47FF, 8'hFF, 1'b1, '{SPACE_NONE, 20'h00000, 1'b0}},
			'{REQ_RD,   16'h4800, 8'h00, 1'b1, '{SPACE_MISC, 20'h00000, 1'b0}},
			'{REQ_RD,   16'h5ABC, 8'h00, 1'b1, '{SPACE_PRG,  20'h01ABC, 1'b0}},
			'{REQ_RD,   16'hD000, 8'h00, 1'b1, '{SPACE_PRG,  20'h07000, 1'b0}},
			'{REQ_RD,   16'hFFFF, 8'hFF, 1'b1, '{SPACE_PRG,  20'h09FFF, 1'b0}},
			'{REQ_PPU,  16'h1FFF, 8'h00, 1'b1, '{SPACE_CHR,  20'h3DFFF, 1'b0}},
			'{REQ_PPU,  16'hE000, 8'hFF, 1'b1, '{SPACE_CHR,  20'h00000, 1'b0}},
			'{REQ_WR,   16'hE000, 8'hFF, 1'b1, '{SPACE_NONE, 20'h00000, 1'b0}},
			'{REQ_PPU,  16'h0FFF, 8'h00, 1'b0, '0},
			'{REQ_WR,   16'hF000, 8'h3F, 1'b0, '0},
			'{REQ_RD,   16'h7FFF, 8'h00, 1'b0, '0},
			'{REQ_WR,   16'hEFFF, 8'h7F, 1'b0, '0},
			'{REQ_WR,   16'hE123, 8'hBF, 1'b0, '0},
			'{REQ_RD,   16'h9FFF, 8'h00, 1'b0, '0},
			'{REQ_RD,   16'hBFFF, 8'h00, 1'b0, '0},
			'{REQ_WR,   16'hC000, 8'h80, 1'b0, '0},
			'{REQ_WR,   16'hD000, 8'h02, 1'b0, '0},
			'{REQ_RD,   16'hC000, 8'h00, 1'b0, '0},
			'{REQ_RD,   16'hCFFF, 8'h00, 1'b0, '0},
			'{REQ_WR,   16'h8000, 8'h02, 1'b0, '0},
			'{REQ_WR,   16'hB000, 8'h00, 1'b0, '0},
			'{REQ_TICK, 16'hFFFF, 8'hFF, 1'b0, '0},
			'{REQ_TICK, 16'h0000, 8'h00, 1'b0, '0},
			'{REQ_TICK, 16'h1234, 8'h55, 1'b0, '0},
			'{REQ_WR,   16'hA000, 8'h00, 1'b1, '{SPACE_NONE, 20'h00000, 1'b0}}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_N; i++)
			send_item(dir_tab[i].kind, dir_tab[i].addr, dir_tab[i].data, dir_tab[i].known,
				dir_tab[i].exp);

		// phases: none, sender idle, receiver stall, both, long receiver hold-off
		for (int ph = 0; ph < 5; ph++) begin
			tx_pct = (ph == 1) ? 68 : (ph == 3) ? 36 : 0;
			rx_pct = (ph == 2) ? 68 : (ph == 3) ? 36 : 0;
			if (ph == 4) hold_req <= 1'b1;
			cnt = (ph == 4) ? 180 : 330;
			for (int n = 0; n < cnt; n++) begin
				sel = $urandom_range(99);
				a = ADDR_W'($urandom);
				d = DATA_W'($urandom);
				if (sel == 0) begin
					// fill the pointer with one bit value, then walk it with auto-increment
					for (int k = 0; k < PTR_W; k++)
						send_item(REQ_WR, {WR_SERIAL, 12'($urandom)},
							{d[7], 7'($urandom)}, 1'b0, '0);
					send_item(REQ_WR, {WR_CTRL, 12'($urandom)}, 8'($urandom) | AUTOINC_BIT,
						1'b0, '0);
					repeat (4)
						send_item(REQ_RD, MISC_WIN_B | 16'($urandom_range(16'h0FFF)),
							8'($urandom), 1'b0, '0);
				end else if (sel < 36) begin
					case ($urandom_range(15))
					0, 1: begin
						a[15:12] = WR_LATCH;
						if ($urandom_range(3) != 0) d = DATA_W'($urandom_range(6));
					end
					2: a[15:12] = WR_CLR;
					3: a[15:12] = WR_DIS;
					4, 5: a[15:12] = WR_EN;
					6, 7, 8: a[15:12] = WR_SERIAL;
					9, 10: a[15:12] = WR_CTRL;
					11, 12: a[15:12] = WR_BANK_E;
					13, 14: a[15:12] = WR_BANK_F;
					default: a[15:12] = 4'($urandom_range(7));
					endcase
					send_item(REQ_WR, a, d, 1'b0, '0);
				end else if (sel < 66) begin
					case ($urandom_range(5))
					0: a = MISC_WIN_A | (a & ~MISC_MASK);
					1: a = MISC_WIN_B | (a & ~MISC_MASK);
					2: a = MISC_WIN_C | (a & ~MISC_MASK);
					default: ;
					endcase
					send_item(REQ_RD, a, d, 1'b0, '0);
				end else if (sel < 90) begin
					send_item(REQ_TICK, a, d, 1'b0, '0);
				end else begin
					send_item(REQ_PPU, a, d, 1'b0, '0);
				end
			end
		end
		in_valid <= 1'b0;
		tx_pct = 0;
		rx_pct = 0;
		while (exp_lookups.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("** cartridge_mapper_banks_irq_serial: PASSED **");
		else
			$display("** cartridge_mapper_banks_irq_serial: FAILED **");
		$finish;
	end
endmodule

### cartridge_mapper_banks_irq_serial.f
rtl/core/cmb_pkg.sv
rtl/core/cmb_bank_mod.sv
rtl/core/cmb_decode.sv
rtl/core/cmb_regs.sv
rtl/core/cartridge_mapper_banks_irq_serial.sv
test/tb_cartridge_mapper_banks_irq_serial.sv
